// ===== sv/kpt_pkg.sv =====
// Shared types, constants and arithmetic helpers for the keyed profit/loss tally.
`default_nettype none

package kpt_pkg;

    localparam int KPT_KEYS   = 256;
    localparam int KPT_BINS   = 11;
    localparam int KPT_NSTATS = 17;
    localparam int SUM_W      = 48;
    localparam int CNT_W      = 32;
    localparam int BIN_W      = $clog2(KPT_BINS);

    localparam logic ACT_ACC  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [4:0] STAT_COUNT = 5'd0;
    localparam logic [4:0] STAT_TOTAL = 5'd1;
    localparam logic [4:0] STAT_NPOS  = 5'd2;
    localparam logic [4:0] STAT_NNEG  = 5'd3;
    localparam logic [4:0] STAT_PSUM  = 5'd4;
    localparam logic [4:0] STAT_NSUM  = 5'd5;
    localparam logic [4:0] STAT_BIN0  = 5'd6;
    localparam logic [4:0] STAT_LAST  = 5'(KPT_NSTATS - 1);

    localparam logic [7:0] LVL_LO_MIN = 8'd1;
    localparam logic [7:0] LVL_LO_MAX = 8'd5;
    localparam logic [7:0] LVL_HI_MIN = 8'd195;
    localparam logic [7:0] LVL_HI_MAX = 8'd199;
    localparam logic [7:0] LVL_HI_OFS = 8'd190;
    localparam logic [BIN_W-1:0] BIN_OTHER = BIN_W'(KPT_BINS - 1);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic [CNT_W-1:0]        cnt;
        logic signed [SUM_W-1:0] total;
        logic [CNT_W-1:0]        npos;
        logic [CNT_W-1:0]        nneg;
        logic signed [SUM_W-1:0] psum;
        logic signed [SUM_W-1:0] nsum;
    } entry_t;

    typedef logic [KPT_BINS-1:0][CNT_W-1:0] bins_t;

    function automatic logic [BIN_W-1:0] level_bin(input logic [7:0] lv);
        logic [7:0] d;
        d = '0;
        if (lv >= LVL_LO_MIN && lv <= LVL_LO_MAX)
        begin
            d = lv - LVL_LO_MIN;
            return BIN_W'(d);
        end
        if (lv >= LVL_HI_MIN && lv <= LVL_HI_MAX)
        begin
            d = lv - LVL_HI_OFS;
            return BIN_W'(d);
        end
        return BIN_OTHER;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] acc,
        input logic signed [31:0]      v
    );
        logic signed [SUM_W:0] s;
        s = (SUM_W+1)'(acc) + (SUM_W+1)'(v);
        if (s[SUM_W] != s[SUM_W-1])
            return s[SUM_W] ? SUM_MIN : SUM_MAX;
        return s[SUM_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== sv/keyed_profit_loss_tally_core.sv =====
// Top level of the keyed profit/loss tally: entry memories, control and read-out emitter.
//
//  channel | direction | fields                                           | handshake
//  --------+-----------+--------------------------------------------------+------------------
//  in      | in        | action, record_key, profit_loss, level_half      | in_valid/in_stall
//  out     | out       | out_key, stat_index, stat_value, last            | out_valid/out_stall
//
//  After reset a clearing pass zeroes both memories row by row, with in_stall high throughout.
//  An accumulate is a memory read, then modify and write back of the same row in ST_MOD.
//  A read first snapshots the row, then makes 17 transfers, one per cycle unless stalled.
//  The input stays stalled while a read-out run is still feeding the output register;
//  the next item is taken once the last result of the run has been loaded there.
//  Keys at or beyond KEYS: accumulates are dropped, reads return a run of zeros.
`default_nettype none

module keyed_profit_loss_tally_core
    import kpt_pkg::*;
#(
    parameter int KEYS = KPT_KEYS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               action,
    input  wire logic [7:0]         record_key,
    input  wire logic signed [31:0] profit_loss,
    input  wire logic [7:0]         level_half,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              out_key,
    output logic [4:0]              stat_index,
    output logic signed [47:0]      stat_value,
    output logic                    last
);

    localparam int IDX_W = $clog2(KEYS);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_MOD   = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] clr_addr_reg, clr_addr_next;

    logic               act_reg;
    logic [7:0]         key_reg;
    logic               kvalid_reg;
    logic signed [31:0] profit_reg;
    logic [BIN_W-1:0]   bin_reg;

    entry_t main_mem [KEYS];
    bins_t  bins_mem [KEYS];
    entry_t rd_main_reg;
    bins_t  rd_bins_reg;

    logic             in_xfer;
    logic             kvalid_in;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    entry_t           mem_wd_main;
    bins_t            mem_wd_bins;
    entry_t           upd_main;
    bins_t            upd_bins;
    logic             snap_load;

    entry_t           snap_main_reg;
    bins_t            snap_bins_reg;
    logic [7:0]       snap_key_reg;
    logic [4:0]       snap_idx_reg;
    logic             snap_active_reg;
    logic signed [47:0] stat_sel;

    logic               out_valid_reg;
    logic [7:0]         out_key_reg;
    logic [4:0]         stat_index_reg;
    logic signed [47:0] stat_value_reg;
    logic               last_reg;
    logic               out_take;

    assign in_stall  = (state_reg != ST_IDLE) || snap_active_reg;
    assign in_xfer   = in_valid && !in_stall;
    assign kvalid_in = 32'(record_key) < 32'(KEYS);
    assign snap_load = (state_reg == ST_MOD) && (act_reg == ACT_READ);

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == IDX_W'(KEYS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_xfer && (action == ACT_READ || kvalid_in))
                    state_next = ST_MOD;
            end
            ST_MOD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            act_reg    <= action;
            key_reg    <= record_key;
            kvalid_reg <= kvalid_in;
            profit_reg <= profit_loss;
            bin_reg    <= level_bin(level_half);
        end
    end

    kpt_update u_update (
        .old_main (rd_main_reg),
        .old_bins (rd_bins_reg),
        .profit   (profit_reg),
        .bin      (bin_reg),
        .new_main (upd_main),
        .new_bins (upd_bins)
    );

    always_comb
    begin
        mem_we      = 1'b0;
        mem_wa      = IDX_W'(key_reg);
        mem_wd_main = upd_main;
        mem_wd_bins = upd_bins;
        if (state_reg == ST_CLEAR)
        begin
            mem_we      = 1'b1;
            mem_wa      = clr_addr_reg;
            mem_wd_main = '0;
            mem_wd_bins = '0;
        end
        else if (state_reg == ST_MOD && act_reg == ACT_ACC && kvalid_reg)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            main_mem[mem_wa] <= mem_wd_main;
            bins_mem[mem_wa] <= mem_wd_bins;
        end
        if (in_xfer)
        begin
            rd_main_reg <= main_mem[IDX_W'(record_key)];
            rd_bins_reg <= bins_mem[IDX_W'(record_key)];
        end
    end

    always_comb
    begin
        stat_sel = '0;
        unique case (snap_idx_reg)
            STAT_COUNT: stat_sel = 48'(snap_main_reg.cnt);
            STAT_TOTAL: stat_sel = snap_main_reg.total;
            STAT_NPOS:  stat_sel = 48'(snap_main_reg.npos);
            STAT_NNEG:  stat_sel = 48'(snap_main_reg.nneg);
            STAT_PSUM:  stat_sel = snap_main_reg.psum;
            STAT_NSUM:  stat_sel = snap_main_reg.nsum;
            default:
            begin
                for (int b = 0; b < KPT_BINS; b++)
                begin
                    if (snap_idx_reg == STAT_BIN0 + 5'(b))
                        stat_sel = 48'(snap_bins_reg[b]);
                end
            end
        endcase
    end

    assign out_take = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_active_reg <= 1'b0;
            snap_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_take)
            begin
                out_valid_reg <= snap_active_reg;
                if (snap_active_reg)
                begin
                    if (snap_idx_reg == STAT_LAST)
                    begin
                        snap_active_reg <= 1'b0;
                        snap_idx_reg    <= '0;
                    end
                    else
                    begin
                        snap_idx_reg <= snap_idx_reg + 5'd1;
                    end
                end
            end
            if (snap_load)
            begin
                snap_active_reg <= 1'b1;
                snap_idx_reg    <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            snap_key_reg  <= key_reg;
            snap_main_reg <= kvalid_reg ? rd_main_reg : '0;
            snap_bins_reg <= kvalid_reg ? rd_bins_reg : '0;
        end
        if (out_take && snap_active_reg)
        begin
            out_key_reg    <= snap_key_reg;
            stat_index_reg <= snap_idx_reg;
            stat_value_reg <= stat_sel;
            last_reg       <= (snap_idx_reg == STAT_LAST);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_key    = out_key_reg;
    assign stat_index = stat_index_reg;
    assign stat_value = stat_value_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> !mem_we)
        else $error("memory write coincides with an input transfer");

    a_read_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        snap_load |=> snap_active_reg && snap_idx_reg == STAT_COUNT)
        else $error("read did not start a read-out run");

    a_last_matches_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (last_reg == (stat_index_reg == STAT_LAST)))
        else $error("last flag disagrees with stat index");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !last_reg) |=>
            (out_valid_reg && stat_index_reg == $past(stat_index_reg) + 5'd1))
        else $error("read-out run broken before last");
`endif

endmodule

`default_nettype wire

// ===== sv/kpt_update.sv =====
// Modify step of one key's entry: saturating sums, counts and level histogram bin.
`default_nettype none

module kpt_update
    import kpt_pkg::*;
(
    input  wire entry_t             old_main,
    input  wire bins_t              old_bins,
    input  wire logic signed [31:0] profit,
    input  wire logic [BIN_W-1:0]   bin,
    output entry_t                  new_main,
    output bins_t                   new_bins
);

    always_comb
    begin
        new_main       = old_main;
        new_main.cnt   = cnt_inc(old_main.cnt);
        new_main.total = sat_add(old_main.total, profit);
        if (profit > 32'sd0)
        begin
            new_main.psum = sat_add(old_main.psum, profit);
            new_main.npos = cnt_inc(old_main.npos);
        end
        else
        begin
            new_main.nsum = sat_add(old_main.nsum, profit);
            new_main.nneg = cnt_inc(old_main.nneg);
        end
    end

    always_comb
    begin
        for (int b = 0; b < KPT_BINS; b++)
        begin
            new_bins[b] = (bin == BIN_W'(b)) ? cnt_inc(old_bins[b]) : old_bins[b];
        end
    end

endmodule

`default_nettype wire
